[src/i2cmes_pkg.sv]
// ----------------------------------------------------------------------------
// i2cmes_pkg
// Shared types and codes for the I2C master EEPROM transfer sequencer.
// ----------------------------------------------------------------------------
package i2cmes_pkg;

   // request kinds
   localparam logic [1:0] REQ_CMD     = 2'd0;
   localparam logic [1:0] REQ_EVENT   = 2'd1;
   localparam logic [1:0] REQ_TIMEOUT = 2'd2;

   // bus status codes
   localparam logic [1:0] ST_START_SENT = 2'd0;
   localparam logic [1:0] ST_BYTE_TX    = 2'd1;
   localparam logic [1:0] ST_BYTE_RX    = 2'd2;
   localparam logic [1:0] ST_OTHER      = 2'd3;

   // clears the R/W bit of the slave address byte
   localparam logic [7:0] ADDR_MASK = 8'hFE;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] target_addr;
      logic [7:0] mem_addr;
      logic [7:0] xfer_len;
      logic       random_read;
      logic       ack_poll;
      logic       send_word_addr;
      logic [1:0] status_code;
      logic       ack_in;
      logic [7:0] rx_byte;
      logic [7:0] tx_byte;
   } req_item_type;

   typedef struct packed {
      logic       load_valid;
      logic [7:0] load_byte;
      logic       tx_taken;
      logic       start_req;
      logic       stop_req;
      logic       ack_out;
      logic       rx_valid;
      logic [7:0] rx_data;
      logic       rx_last;
      logic       bus_reset;
      logic       busy_res;
      logic       cmd_rejected;
   } rsp_item_type;

endpackage

[src/i2c_master_eeprom_transfer_sequencer.sv]
// ----------------------------------------------------------------------------
// i2c_master_eeprom_transfer_sequencer
// Master-side sequencer for I2C register / EEPROM random read and write.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one beat is either a start command (addresses, length, flags),
//            a bus status event from the bit engine, or an SCL-low timeout.
//   rsp_*  : exactly one beat comes back per request beat, carrying what the
//            bit engine must do next (load a byte, START, STOP, ACK/NACK),
//            any received byte for the host, and the busy flag after it.
// A request taken in one cycle gives its response beat in the next.
// Throughput is one beat per cycle unless rsp_ stalls; the sequencer
// state is updated by short flag logic in the same cycle the beat is taken.
// The response register doubles as the only buffer: a new request is taken
// whenever that register is empty or is being drained in the same cycle, so
// a stall on rsp_ holds the response and pushes back on req_ by one beat.
// Reset (synchronous, active high) empties the response register and puts
// the sequencer idle with all held addresses, length and count at zero.
// ----------------------------------------------------------------------------
module i2c_master_eeprom_transfer_sequencer (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  i2cmes_pkg::req_item_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output i2cmes_pkg::rsp_item_type rsp_data
);

   // sequencer state
   logic       busy_ff,      busy_in;
   logic       dir_read_ff,  dir_read_in;
   logic       pend_wa_ff,   pend_wa_in;
   logic       random_ff,    random_in;
   logic       poll_ff,      poll_in;
   logic       restart_ff,   restart_in;
   logic [7:0] count_ff,     count_in;
   logic [7:0] slave_ff,     slave_in;
   logic [7:0] word_ff,      word_in;
   logic [7:0] length_ff,    length_in;

   // response register
   logic                     rsp_valid_ff, rsp_valid_in;
   i2cmes_pkg::rsp_item_type rsp_data_ff,  rsp_data_in;

   logic       req_take;
   logic       rx_store;
   logic [7:0] rx_count;

   // take a beat when the response slot is free or draining this cycle
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_take  = req_valid & ~req_stall;

   // receive path: count after a possible store
   assign rx_store = (count_ff < length_ff);
   assign rx_count = rx_store ? count_ff + 8'd1 : count_ff;

   always_comb begin
      busy_in     = busy_ff;
      dir_read_in = dir_read_ff;
      pend_wa_in  = pend_wa_ff;
      random_in   = random_ff;
      poll_in     = poll_ff;
      restart_in  = restart_ff;
      count_in    = count_ff;
      slave_in    = slave_ff;
      word_in     = word_ff;
      length_in   = length_ff;
      rsp_data_in = '0;

      case (req_data.req_type)
         i2cmes_pkg::REQ_CMD: begin
            if (busy_ff) begin
               rsp_data_in.cmd_rejected = 1'b1;
            end else begin
               // latch the transfer and ask for START; direction opens as write
               busy_in     = 1'b1;
               slave_in    = req_data.target_addr;
               word_in     = req_data.mem_addr;
               length_in   = req_data.xfer_len;
               random_in   = req_data.random_read;
               poll_in     = req_data.ack_poll;
               pend_wa_in  = req_data.send_word_addr;
               dir_read_in = 1'b0;
               restart_in  = 1'b0;
               count_in    = 8'd0;
               rsp_data_in.start_req = 1'b1;
            end
         end
         i2cmes_pkg::REQ_EVENT: begin
            case (req_data.status_code)
               i2cmes_pkg::ST_START_SENT: begin
                  // address byte with R/W in bit 0, restart the count
                  rsp_data_in.load_valid = 1'b1;
                  rsp_data_in.load_byte  = (slave_ff & i2cmes_pkg::ADDR_MASK)
                                           | {7'd0, dir_read_ff};
                  count_in = 8'd0;
               end
               i2cmes_pkg::ST_BYTE_TX: begin
                  if (!req_data.ack_in) begin
                     // NACK: poll again with START, or give up
                     if (poll_ff) begin
                        rsp_data_in.start_req = 1'b1;
                     end else begin
                        rsp_data_in.bus_reset = 1'b1;
                        busy_in = 1'b0;
                     end
                  end else if (restart_ff) begin
                     rsp_data_in.start_req = 1'b1;
                     restart_in = 1'b0;
                  end else if (pend_wa_ff) begin
                     pend_wa_in = 1'b0;
                     rsp_data_in.load_valid = 1'b1;
                     rsp_data_in.load_byte  = word_ff;
                     if (random_ff) begin
                        restart_in  = 1'b1;
                        dir_read_in = 1'b1;
                     end
                  end else if (!dir_read_ff) begin
                     if (count_ff < length_ff) begin
                        rsp_data_in.load_valid = 1'b1;
                        rsp_data_in.load_byte  = req_data.tx_byte;
                        rsp_data_in.tx_taken   = 1'b1;
                        count_in = count_ff + 8'd1;
                     end else begin
                        rsp_data_in.stop_req = 1'b1;
                        busy_in = 1'b0;
                     end
                  end
               end
               i2cmes_pkg::ST_BYTE_RX: begin
                  count_in = rx_count;
                  if (rx_store) begin
                     rsp_data_in.rx_valid = 1'b1;
                     rsp_data_in.rx_data  = req_data.rx_byte;
                     rsp_data_in.ack_out  = 1'b1;
                  end
                  // final byte (or none wanted): NACK and STOP
                  if (rx_count == length_ff) begin
                     busy_in = 1'b0;
                     rsp_data_in.ack_out  = 1'b0;
                     rsp_data_in.stop_req = 1'b1;
                     rsp_data_in.rx_last  = rx_store;
                  end
               end
               default: begin
                  rsp_data_in.bus_reset = 1'b1;
                  busy_in = 1'b0;
               end
            endcase
         end
         i2cmes_pkg::REQ_TIMEOUT: begin
            rsp_data_in.bus_reset = 1'b1;
            busy_in = 1'b0;
         end
         default: begin
            // no action
         end
      endcase

      rsp_data_in.busy_res = busy_in;
   end

   // response slot fills on a taken beat, empties when drained
   assign rsp_valid_in = req_take | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         busy_ff      <= 1'b0;
         dir_read_ff  <= 1'b0;
         pend_wa_ff   <= 1'b0;
         random_ff    <= 1'b0;
         poll_ff      <= 1'b0;
         restart_ff   <= 1'b0;
         count_ff     <= 8'd0;
         slave_ff     <= 8'd0;
         word_ff      <= 8'd0;
         length_ff    <= 8'd0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_take) begin
            busy_ff     <= busy_in;
            dir_read_ff <= dir_read_in;
            pend_wa_ff  <= pend_wa_in;
            random_ff   <= random_in;
            poll_ff     <= poll_in;
            restart_ff  <= restart_in;
            count_ff    <= count_in;
            slave_ff    <= slave_in;
            word_ff     <= word_in;
            length_ff   <= length_in;
         end
      end
   end

   // payload: load on a taken beat, hold otherwise
   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[src/i2cmes_checker.sv]
// ----------------------------------------------------------------------------
// i2cmes_checker
// Port-level checks for the I2C master EEPROM transfer sequencer.
// ----------------------------------------------------------------------------
module i2cmes_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input i2cmes_pkg::rsp_item_type rsp_data
);

   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response beat changed");

   // reset empties the response slot
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // bus reset and STOP both free the transfer
   a_free: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.bus_reset || rsp_data.stop_req) |-> !rsp_data.busy_res)
      else $error("busy held after bus reset or STOP");

   // last received byte is a stored byte with NACK and STOP
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.rx_last |->
         rsp_data.rx_valid && rsp_data.stop_req && !rsp_data.ack_out)
      else $error("last byte without NACK and STOP");

   // a rejected command leaves the transfer running
   a_reject: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.cmd_rejected |-> rsp_data.busy_res)
      else $error("rejected command dropped busy");

endmodule

bind i2c_master_eeprom_transfer_sequencer i2cmes_checker u_i2cmes_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
